// File: rtl/core/tce_pkg.sv
// ----------------------------------------------------------------------------
// tce_pkg
// shared types and constants of the toy cpu execute unit
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int unsigned ActW     = 3;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned DataW    = 8;
  localparam int unsigned AddrW    = 8;
  localparam int unsigned NumRegs  = 1 << RegIdxW;
  localparam int unsigned MemDepth = 1 << AddrW;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  typedef enum logic [ActW-1:0] {
    ACT_COPY  = 3'd0,
    ACT_LDI   = 3'd1,
    ACT_STORE = 3'd2,
    ACT_LOAD  = 3'd3,
    ACT_ADD   = 3'd4,
    ACT_SUB   = 3'd5,
    ACT_XOR   = 3'd6,
    ACT_END   = 3'd7
  } action_t;

  typedef struct packed {
    action_t              action;
    logic [RegIdxW-1:0]   first_reg;
    logic [RegIdxW-1:0]   second_reg;
    logic [DataW-1:0]     immediate;
    logic                 program_start;
  } instr_t;

  typedef struct packed {
    logic                 reg_written;
    logic [RegIdxW-1:0]   reg_index;
    logic [DataW-1:0]     reg_value;
    logic                 mem_written;
    logic [AddrW-1:0]     mem_address;
    logic [DataW-1:0]     mem_value;
    logic                 is_halted;
  } result_t;

  // last write into each store, kept for read-after-write bypass
  typedef struct packed {
    logic                 valid;
    logic [RegIdxW-1:0]   idx;
    logic [DataW-1:0]     data;
  } reg_wr_t;

  typedef struct packed {
    logic                 valid;
    logic [AddrW-1:0]     addr;
    logic [DataW-1:0]     data;
  } mem_wr_t;

endpackage

// File: rtl/core/tce_regfile.sv
// ----------------------------------------------------------------------------
// tce_regfile
// 8 x 8 register file, two registered read ports, one write port
// ----------------------------------------------------------------------------
module tce_regfile (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [tce_pkg::RegIdxW-1:0]   rd_addr_a,
  input  logic [tce_pkg::RegIdxW-1:0]   rd_addr_b,
  output logic [tce_pkg::DataW-1:0]     rd_data_a,
  output logic [tce_pkg::DataW-1:0]     rd_data_b,
  input  logic                          wr_en,
  input  logic [tce_pkg::RegIdxW-1:0]   wr_addr,
  input  logic [tce_pkg::DataW-1:0]     wr_data
);
  import tce_pkg::*;

  logic [DataW-1:0]   mem [NumRegs];
  logic [NumRegs-1:0] valid_r;
  logic [DataW-1:0]   rd_data_a_r;
  logic [DataW-1:0]   rd_data_b_r;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a_r <= valid_r[rd_addr_a] ? mem[rd_addr_a] : '0;
      rd_data_b_r <= valid_r[rd_addr_b] ? mem[rd_addr_b] : '0;
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

// File: rtl/core/tce_dmem.sv
// ----------------------------------------------------------------------------
// tce_dmem
// 256 x 8 data memory, one registered read port, one write port
// ----------------------------------------------------------------------------
module tce_dmem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [tce_pkg::AddrW-1:0]   rd_addr,
  output logic [tce_pkg::DataW-1:0]   rd_data,
  input  logic                        wr_en,
  input  logic [tce_pkg::AddrW-1:0]   wr_addr,
  input  logic [tce_pkg::DataW-1:0]   wr_data
);
  import tce_pkg::*;

  logic [DataW-1:0]    mem [MemDepth];
  logic [MemDepth-1:0] valid_r;
  logic [DataW-1:0]    rd_data_r;

  // one valid flop per byte stands in for a clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/tce_alu.sv
// ----------------------------------------------------------------------------
// tce_alu
// executes one instruction on bypassed operands, gives result and halt state
// ----------------------------------------------------------------------------
module tce_alu (
  input  tce_pkg::instr_t              instr,
  input  logic [tce_pkg::DataW-1:0]    op_a,
  input  logic [tce_pkg::DataW-1:0]    op_b,
  input  logic [tce_pkg::DataW-1:0]    mem_data,
  input  logic                         halted,
  output tce_pkg::result_t             res,
  output logic                         halted_nxt
);
  import tce_pkg::*;

  logic halted_eff;

  assign halted_eff = halted && !instr.program_start;

  always_comb begin
    res        = '0;
    halted_nxt = halted_eff;
    if (halted_eff) begin
      res.is_halted = 1'b1;
    end else begin
      res.reg_written = 1'b1;
      res.reg_index   = instr.first_reg;
      unique case (instr.action)
        ACT_COPY:  res.reg_value = op_b;
        ACT_LDI:   res.reg_value = instr.immediate;
        ACT_STORE: begin
          res.reg_written = 1'b0;
          res.reg_index   = '0;
          res.mem_written = 1'b1;
          res.mem_address = instr.immediate;
          res.mem_value   = op_b;
        end
        ACT_LOAD:  res.reg_value = mem_data;
        ACT_ADD:   res.reg_value = op_a + op_b;
        ACT_SUB:   res.reg_value = op_a - op_b;
        ACT_XOR:   res.reg_value = op_a ^ op_b;
        ACT_END: begin
          res.reg_written = 1'b0;
          res.reg_index   = '0;
          res.is_halted   = 1'b1;
          halted_nxt      = 1'b1;
        end
        default: res = '0;
      endcase
    end
  end

endmodule

// File: rtl/core/toy_cpu_execute_unit.sv
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit
// execute stage of a small 8-bit machine with register file and data memory
// ----------------------------------------------------------------------------
// One instruction is taken per clock unless the output stalls, and one
// result per instruction comes out. On the accepting edge the register file
// (both operands) and the data memory (at the immediate) are read; once the
// output register is free the bypassed operands are combined, the write goes
// back to its store and the result lands in the output register. The
// sustained rate of one item per cycle is set by the single write port of
// each store and the registered reads, with a bypass from the last register
// and the last memory write covering back-to-back dependencies. Both stores
// read as zero after reset through per-entry valid flops, so no clearing
// pass is needed. An end instruction halts the machine; later instructions
// only report is_halted until one arrives with program_start set. in_tready
// depends on out_tready combinationally when both pipeline slots are full.
// ----------------------------------------------------------------------------
module toy_cpu_execute_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // input instruction stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [2:0] action, [5:3] first_reg, [8:6] second_reg, [16:9] immediate, rest zero
  input  logic [tce_pkg::InDataW-1:0]      in_tdata,
  // [0] program_start
  input  logic                             in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] reg_written, [3:1] reg_index, [11:4] reg_value, [12] mem_written,
  // [20:13] mem_address, [28:21] mem_value, rest zero
  output logic [tce_pkg::OutDataW-1:0]     out_tdata,
  // [0] is_halted
  output logic                             out_tuser
);
  import tce_pkg::*;

  // input unpack
  instr_t  in_instr;
  logic    in_xfer;

  // execute stage
  logic    s1_valid_r, s1_valid_nxt;
  instr_t  s1_instr_r;
  logic    s1_fire;
  logic    out_free;

  // store read data and bypassed operands
  logic [DataW-1:0] rf_rd_a, rf_rd_b, dm_rd;
  logic [DataW-1:0] op_a, op_b, op_m;

  // last writes for bypass
  reg_wr_t last_reg_r, last_reg_nxt;
  mem_wr_t last_mem_r, last_mem_nxt;

  logic    halted_r, halted_nxt, alu_halted;
  result_t res;

  // output register
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OutDataW-1:0] out_tdata_r;
  logic                out_tuser_r;

  assign in_instr.action        = action_t'(in_tdata[2:0]);
  assign in_instr.first_reg     = in_tdata[5:3];
  assign in_instr.second_reg    = in_tdata[8:6];
  assign in_instr.immediate     = in_tdata[16:9];
  assign in_instr.program_start = in_tuser;

  // stage 1 moves on once the output register is empty or being drained
  assign out_free  = !out_tvalid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_xfer   = in_tvalid && in_tready;

  // reads issued at the accepting edge
  tce_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_xfer),
    .rd_addr_a (in_instr.first_reg),
    .rd_addr_b (in_instr.second_reg),
    .rd_data_a (rf_rd_a),
    .rd_data_b (rf_rd_b),
    .wr_en     (s1_fire && res.reg_written),
    .wr_addr   (res.reg_index),
    .wr_data   (res.reg_value)
  );

  tce_dmem u_dmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_addr (in_instr.immediate),
    .rd_data (dm_rd),
    .wr_en   (s1_fire && res.mem_written),
    .wr_addr (res.mem_address),
    .wr_data (res.mem_value)
  );

  // the write of the previous item can land on the same edge as this read,
  // so the newest write to each store is bypassed over the read data
  always_comb begin
    op_a = rf_rd_a;
    op_b = rf_rd_b;
    op_m = dm_rd;
    if (last_reg_r.valid && last_reg_r.idx == s1_instr_r.first_reg) begin
      op_a = last_reg_r.data;
    end
    if (last_reg_r.valid && last_reg_r.idx == s1_instr_r.second_reg) begin
      op_b = last_reg_r.data;
    end
    if (last_mem_r.valid && last_mem_r.addr == s1_instr_r.immediate) begin
      op_m = last_mem_r.data;
    end
  end

  tce_alu u_alu (
    .instr      (s1_instr_r),
    .op_a       (op_a),
    .op_b       (op_b),
    .mem_data   (op_m),
    .halted     (halted_r),
    .res        (res),
    .halted_nxt (alu_halted)
  );

  // next-state logic
  always_comb begin
    s1_valid_nxt   = s1_valid_r;
    halted_nxt     = halted_r;
    last_reg_nxt   = last_reg_r;
    last_mem_nxt   = last_mem_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (s1_fire) begin
      s1_valid_nxt   = 1'b0;
      halted_nxt     = alu_halted;
      out_tvalid_nxt = 1'b1;
      if (res.reg_written) begin
        last_reg_nxt = '{valid: 1'b1, idx: res.reg_index, data: res.reg_value};
      end
      if (res.mem_written) begin
        last_mem_nxt = '{valid: 1'b1, addr: res.mem_address, data: res.mem_value};
      end
    end
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      halted_r     <= 1'b0;
      last_reg_r   <= '0;
      last_mem_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      halted_r     <= halted_nxt;
      last_reg_r   <= last_reg_nxt;
      last_mem_r   <= last_mem_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_instr_r <= in_instr;
    end
    if (s1_fire) begin
      out_tdata_r <= {3'b000, res.mem_value, res.mem_address, res.mem_written,
                      res.reg_value, res.reg_index, res.reg_written};
      out_tuser_r <= res.is_halted;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // a halted result never carries a write
  a_halt_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && res.is_halted |-> !res.reg_written && !res.mem_written)
    else $error("halted result carries a write");

  // at most one store is written per instruction
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |-> !(res.reg_written && res.mem_written))
    else $error("register and memory written by one instruction");

  // an executed end leaves the machine halted
  a_end_halts: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_instr_r.action == ACT_END |=> halted_r)
    else $error("end did not halt");

  // halted state only changes when an instruction retires
  a_halt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(halted_r))
    else $error("halted changed without a retiring instruction");

  // a retiring instruction always fills the output register
  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_tvalid_r)
    else $error("retired instruction produced no result");

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the toy cpu execute unit
// ----------------------------------------------------------------------------
// Starts with a short table of directed instructions: operand and address
// extremes, every action, the halt and restart cases and a copy onto itself.
// Random programs with occasional end instructions and restarts follow. Each
// instruction runs through a model of registers, data memory and halt flag;
// the typed result of a table row, else the prediction, is queued and
// compared field by field with the next result. Both streams stall randomly.
// ----------------------------------------------------------------------------
module testbench;
  import tce_pkg::*;

  localparam int unsigned ClkPeriod   = 20;
  localparam int unsigned ResetCycles = 11;
  localparam int unsigned RandomItems = 950;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned DrainCycles = 10;

  // one row of the directed table; res is used only when typed is set
  typedef struct packed {
    instr_t  ins;
    logic    typed;
    result_t res;
  } step_row_t;

  localparam result_t NoRes   = '0;
  localparam result_t HaltRes = '{1'b0, 3'd0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b1};

  localparam int unsigned NumRows = 24;
  localparam step_row_t DirectedRows [NumRows] = '{
    // reads right after reset see zeros
    '{'{ACT_COPY,  3'd7, 3'd0, 8'h00, 1'b0}, 1'b1,
      '{1'b1, 3'd7, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0}},
    '{'{ACT_LOAD,  3'd3, 3'd0, 8'h00, 1'b0}, 1'b1,
      '{1'b1, 3'd3, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0}},
    '{'{ACT_LOAD,  3'd4, 3'd0, 8'hff, 1'b0}, 1'b1,
      '{1'b1, 3'd4, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0}},
    // immediates at the extremes
    '{'{ACT_LDI,   3'd0, 3'd0, 8'hff, 1'b0}, 1'b1,
      '{1'b1, 3'd0, 8'hff, 1'b0, 8'h00, 8'h00, 1'b0}},
    '{'{ACT_LDI,   3'd7, 3'd7, 8'h00, 1'b0}, 1'b1,
      '{1'b1, 3'd7, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0}},
    '{'{ACT_LDI,   3'd1, 3'd0, 8'h80, 1'b0}, 1'b1,
      '{1'b1, 3'd1, 8'h80, 1'b0, 8'h00, 8'h00, 1'b0}},
    // arithmetic wrap-around, back to back dependencies
    '{'{ACT_ADD,   3'd0, 3'd0, 8'h00, 1'b0}, 1'b0, NoRes},
    '{'{ACT_ADD,   3'd1, 3'd1, 8'h00, 1'b0}, 1'b0, NoRes},
    '{'{ACT_SUB,   3'd7, 3'd0, 8'h00, 1'b0}, 1'b0, NoRes},
    '{'{ACT_XOR,   3'd0, 3'd7, 8'h00, 1'b0}, 1'b0, NoRes},
    // store to both ends of memory, then read back
    '{'{ACT_STORE, 3'd0, 3'd0, 8'hff, 1'b0}, 1'b0, NoRes},
    '{'{ACT_STORE, 3'd7, 3'd7, 8'h00, 1'b0}, 1'b0, NoRes},
    '{'{ACT_LOAD,  3'd2, 3'd0, 8'hff, 1'b0}, 1'b0, NoRes},
    // copy onto itself still reports the write
    '{'{ACT_COPY,  3'd2, 3'd2, 8'h00, 1'b0}, 1'b0, NoRes},
    // program start while running is harmless
    '{'{ACT_LDI,   3'd5, 3'd0, 8'h5a, 1'b1}, 1'b1,
      '{1'b1, 3'd5, 8'h5a, 1'b0, 8'h00, 8'h00, 1'b0}},
    '{'{ACT_END,   3'd0, 3'd0, 8'h00, 1'b0}, 1'b1, HaltRes},
    // ignored while halted
    '{'{ACT_ADD,   3'd0, 3'd0, 8'h00, 1'b0}, 1'b1, HaltRes},
    '{'{ACT_STORE, 3'd0, 3'd1, 8'h10, 1'b0}, 1'b1, HaltRes},
    '{'{ACT_END,   3'd0, 3'd0, 8'h00, 1'b0}, 1'b1, HaltRes},
    // restart executes the instruction that carries it
    '{'{ACT_LDI,   3'd6, 3'd0, 8'ha5, 1'b1}, 1'b1,
      '{1'b1, 3'd6, 8'ha5, 1'b0, 8'h00, 8'h00, 1'b0}},
    '{'{ACT_END,   3'd0, 3'd0, 8'h00, 1'b0}, 1'b1, HaltRes},
    // restart on an end halts again at once
    '{'{ACT_END,   3'd7, 3'd7, 8'hff, 1'b1}, 1'b1, HaltRes},
    '{'{ACT_COPY,  3'd3, 3'd0, 8'h00, 1'b1}, 1'b0, NoRes},
    '{'{ACT_SUB,   3'd6, 3'd6, 8'h00, 1'b0}, 1'b0, NoRes}
  };

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                in_tuser   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;

  // architectural state as the machine should see it
  logic [DataW-1:0] arch_regs [NumRegs];
  logic [DataW-1:0] arch_mem  [MemDepth];
  logic             arch_halted;

  result_t pending_results [$];
  int      error_count  = 0;
  int      idle_cycles  = 0;
  bit      steady_flow  = 1'b0;  // no gaps and no stalls while set

  toy_cpu_execute_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // mostly no pause or a short one, now and then a long one
  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_flow || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // executes one instruction on the architectural state
  function automatic result_t execute_instr(instr_t ins);
    result_t          res;
    logic [DataW-1:0] dst_val;
    logic [DataW-1:0] src_val;
    logic [DataW-1:0] new_val;
    bit               writes_reg;
    res        = '0;
    new_val    = '0;
    writes_reg = 1'b1;
    if (ins.program_start) arch_halted = 1'b0;
    if (arch_halted) begin
      res.is_halted = 1'b1;
      return res;
    end
    dst_val = arch_regs[ins.first_reg];
    src_val = arch_regs[ins.second_reg];
    case (ins.action)
      ACT_COPY:  new_val = src_val;
      ACT_LDI:   new_val = ins.immediate;
      ACT_STORE: begin
        writes_reg               = 1'b0;
        arch_mem[ins.immediate]  = src_val;
        res.mem_written          = 1'b1;
        res.mem_address          = ins.immediate;
        res.mem_value            = src_val;
      end
      ACT_LOAD:  new_val = arch_mem[ins.immediate];
      ACT_ADD:   new_val = dst_val + src_val;
      ACT_SUB:   new_val = dst_val - src_val;
      ACT_XOR:   new_val = dst_val ^ src_val;
      default: begin
        writes_reg    = 1'b0;
        arch_halted   = 1'b1;
        res.is_halted = 1'b1;
      end
    endcase
    if (writes_reg) begin
      arch_regs[ins.first_reg] = new_val;
      res.reg_written          = 1'b1;
      res.reg_index            = ins.first_reg;
      res.reg_value            = new_val;
    end
    return res;
  endfunction

  // random program content; ends are rare so programs run long
  function automatic instr_t make_random_instr();
    instr_t ins;
    int     roll;
    roll           = $urandom_range(0, 99);
    ins.action     = (roll < 4) ? ACT_END : action_t'($urandom_range(0, 6));
    ins.first_reg  = RegIdxW'($urandom_range(0, NumRegs - 1));
    ins.second_reg = RegIdxW'($urandom_range(0, NumRegs - 1));
    // half the addresses fall in a small window so loads hit earlier stores
    ins.immediate  = ($urandom_range(0, 1) == 0) ? DataW'($urandom_range(0, 15))
                                                 : DataW'($urandom_range(0, 255));
    // restart soon after a halt, and rarely while running
    roll              = $urandom_range(0, 99);
    ins.program_start = arch_halted ? (roll < 30) : (roll < 5);
    return ins;
  endfunction

  // one instruction transfer; prediction is taken at the accepting edge
  task automatic issue_instr(input instr_t ins, input bit typed, input result_t typed_res,
                             input int gap);
    result_t predicted;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(InDataW - 17){1'b0}}, ins.immediate, ins.second_reg, ins.first_reg,
                  ins.action};
    in_tuser  <= ins.program_start;
    do @(posedge clk); while (!in_tready);
    predicted = execute_instr(ins);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // reset and stimulus
  initial begin
    for (int i = 0; i < NumRegs; i++) arch_regs[i] = '0;
    for (int i = 0; i < MemDepth; i++) arch_mem[i] = '0;
    arch_halted = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (DirectedRows[i]) begin
      issue_instr(DirectedRows[i].ins, DirectedRows[i].typed, DirectedRows[i].res,
                  draw_gap());
    end

    // hold off until the pipeline has drained completely
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);

    // random programs in five stretches, one of them without any gaps
    for (int chunk = 0; chunk < 5; chunk++) begin
      steady_flow = (chunk == 1);
      if (chunk == 3) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
      end
      for (int n = 0; n < RandomItems / 5; n++) begin
        issue_instr(make_random_instr(), 1'b0, NoRes, draw_gap());
      end
    end
    steady_flow = 1'b0;
    @(negedge clk);
    in_tvalid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // result side back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0 && !steady_flow) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = draw_gap();
      end
    end
  end

  // compare every result transfer with the oldest queued result
  always @(posedge clk) begin
    result_t got;
    result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      got.reg_written = out_tdata[0];
      got.reg_index   = out_tdata[3:1];
      got.reg_value   = out_tdata[11:4];
      got.mem_written = out_tdata[12];
      got.mem_address = out_tdata[20:13];
      got.mem_value   = out_tdata[28:21];
      got.is_halted   = out_tuser;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: tdata %h tuser %b",
               out_tdata, out_tuser);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (got.reg_written !== exp_res.reg_written) begin
          $error("reg_written: expected %0d, got %0d", exp_res.reg_written, got.reg_written);
          error_count++;
        end
        if (got.reg_index !== exp_res.reg_index) begin
          $error("reg_index: expected %0d, got %0d", exp_res.reg_index, got.reg_index);
          error_count++;
        end
        if (got.reg_value !== exp_res.reg_value) begin
          $error("reg_value: expected %h, got %h", exp_res.reg_value, got.reg_value);
          error_count++;
        end
        if (got.mem_written !== exp_res.mem_written) begin
          $error("mem_written: expected %0d, got %0d", exp_res.mem_written, got.mem_written);
          error_count++;
        end
        if (got.mem_address !== exp_res.mem_address) begin
          $error("mem_address: expected %h, got %h", exp_res.mem_address, got.mem_address);
          error_count++;
        end
        if (got.mem_value !== exp_res.mem_value) begin
          $error("mem_value: expected %h, got %h", exp_res.mem_value, got.mem_value);
          error_count++;
        end
        if (got.is_halted !== exp_res.is_halted) begin
          $error("is_halted: expected %0d, got %0d", exp_res.is_halted, got.is_halted);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
